// ===== sv/maf_pkg.sv =====
package maf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEN_W = 6;
	localparam int MAX_WINDOW_DEF = 32;
	localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(1);

	typedef struct packed {
		logic idle;
		logic done;
	} div_stat_t;

endpackage

// ===== sv/maf_cell.sv =====
module maf_cell import maf_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clr,
	input  logic                       shift,
	input  logic signed [SAMPLE_W-1:0] din,
	input  logic        [LEN_W-1:0]    len,
	output logic signed [SAMPLE_W-1:0] dout,
	output logic signed [SAMPLE_W-1:0] tap
);

	logic signed [SAMPLE_W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (clr) begin
			data_q <= '0;
		end else if (shift) begin
			data_q <= din;
		end
	end

	assign dout = data_q;
	// oldest sample still in the window
	assign tap = (int'(len) == IDX + 1) ? data_q : '0;

endmodule

// ===== sv/maf_div.sv =====
module maf_div import maf_pkg::*; #(
	parameter int DVD_W = 21
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [DVD_W-1:0]    dividend,
	input  logic        [LEN_W-1:0]    divisor,
	input  logic                       take,
	output div_stat_t                  stat,
	output logic signed [SAMPLE_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABS,
		ST_RUN,
		ST_SIGN,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              neg_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [LEN_W-1:0]  dsr_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			neg_q <= 1'b0;
			dvd_q <= '0;
			dsr_q <= '0;
			rem_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						dvd_q <= dividend;
						dsr_q <= divisor;
						neg_q <= dividend[DVD_W-1];
						state_q <= ST_ABS;
					end
				end
				ST_ABS: begin
					// magnitude of the most negative sum still fits unsigned
					if (neg_q) begin
						dvd_q <= -dvd_q;
					end
					rem_q <= '0;
					cnt_q <= CNT_W'(DVD_W - 1);
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					// restoring step, one quotient bit per cycle
					rem_q <= ge ? LEN_W'(trial - {1'b0, dsr_q}) : trial[LEN_W-1:0];
					dvd_q <= {dvd_q[DVD_W-2:0], ge};
					if (cnt_q == '0) begin
						state_q <= ST_SIGN;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_SIGN: begin
					if (neg_q) begin
						dvd_q <= -dvd_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.idle = (state_q == ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign quotient = dvd_q[SAMPLE_W-1:0];

endmodule

// ===== sv/moving_average_filter.sv =====
// Simple moving average over the last window_length signed 16-bit samples
// (at most MAX_WINDOW), truncated toward zero. The history is a row of shift
// cells plus a running sum; writing window_length clears both, and 0 passes
// samples through. A new request is accepted only once the radix-2 restoring
// divider, which forms the mean one quotient bit per cycle, has finished the
// last one and is idle again. A single result waiting on out_ready does not
// hold off the next input request; a second finished result held behind it
// does.
module moving_average_filter import maf_pkg::*; #(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic        [LEN_W-1:0]    cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] average
);

	localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

	logic        [LEN_W-1:0]    wl_q;
	logic        [LEN_W-1:0]    eff_len;
	logic                       bypass;
	logic                       accept;
	logic                       take;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SUM_W-1:0]    sum_next;
	logic signed [SUM_W-1:0]    dividend;
	logic        [LEN_W-1:0]    divisor;
	logic signed [SAMPLE_W-1:0] oldest;
	logic signed [SAMPLE_W-1:0] quotient;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] average_q;
	div_stat_t                  div_stat;

	logic signed [SAMPLE_W-1:0] cell_out [MAX_WINDOW];
	logic signed [SAMPLE_W-1:0] cell_tap [MAX_WINDOW];

	always_comb begin
		if (int'(wl_q) > MAX_WINDOW) begin
			eff_len = LEN_W'(MAX_WINDOW);
		end else begin
			eff_len = wl_q;
		end
	end

	assign bypass = (wl_q == '0);
	assign in_ready = div_stat.idle;
	assign accept = in_valid && in_ready;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		maf_cell #(
			.IDX(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.clr   (cfg_wen),
			.shift (accept && !bypass),
			.din   ((i == 0) ? sample : cell_out[(i == 0) ? 0 : i - 1]),
			.len   (eff_len),
			.dout  (cell_out[i]),
			.tap   (cell_tap[i])
		);
	end

	always_comb begin
		oldest = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			oldest = oldest | cell_tap[i];
		end
	end

	assign sum_next = sum_q
		- {{(SUM_W - SAMPLE_W){oldest[SAMPLE_W-1]}}, oldest}
		+ {{(SUM_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};

	assign dividend = bypass ? {{(SUM_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample} : sum_next;
	assign divisor = bypass ? LEN_W'(1) : eff_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= WINDOW_RESET;
			sum_q <= '0;
		end else if (cfg_wen) begin
			wl_q <= cfg_wdata;
			sum_q <= '0;
		end else if (accept && !bypass) begin
			sum_q <= sum_next;
		end
	end

	maf_div #(
		.DVD_W(SUM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.dividend(dividend),
		.divisor (divisor),
		.take    (take),
		.stat    (div_stat),
		.quotient(quotient)
	);

	assign take = div_stat.done && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			average_q <= quotient;
		end
	end

	assign out_valid = out_valid_q;
	assign average = average_q;

endmodule

// ===== sim/moving_average_filter_tb.sv =====
module moving_average_filter_tb;
	import maf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1700;
	localparam int SETTLE_CYCLES = 30;
	localparam int LONG_HOLD = 600;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY3} rx_mode_t;

	typedef struct packed {
		logic                       set_len;
		logic        [LEN_W-1:0]    len;
		logic signed [SAMPLE_W-1:0] smp;
		logic                       typed;
		logic signed [SAMPLE_W-1:0] want;
	} step_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_wen;
	logic        [LEN_W-1:0]    cfg_wdata;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [SAMPLE_W-1:0] average;

	logic signed [SAMPLE_W-1:0] delay_line [MAX_WINDOW_DEF];
	int                         window_total;
	logic        [LEN_W-1:0]    win_len;
	logic signed [SAMPLE_W-1:0] pending_means [$];
	logic signed [SAMPLE_W-1:0] prev_sample;
	logic signed [SAMPLE_W-1:0] head_mean;
	int                         errors;
	int                         results_seen;
	int unsigned                cycle_count;

	// directed requests: extremes, bypass, clamped window, truncation toward zero
	step_t steps [24] = '{
		'{1'b0, 6'd0,  16'sh7FFF, 1'b1, 16'sh7FFF},
		'{1'b0, 6'd0,  16'sh8000, 1'b1, 16'sh8000},
		'{1'b0, 6'd0,  16'sh0000, 1'b1, 16'sh0000},
		'{1'b0, 6'd0,  -16'sd1,   1'b1, -16'sd1},
		'{1'b1, 6'd0,  16'sh8000, 1'b1, 16'sh8000},
		'{1'b0, 6'd0,  16'sh7FFF, 1'b1, 16'sh7FFF},
		'{1'b0, 6'd0,  16'sh5555, 1'b1, 16'sh5555},
		'{1'b0, 6'd0,  16'shAAAA, 1'b1, 16'shAAAA},
		'{1'b1, 6'd32, 16'sh7FFF, 1'b1, 16'sd1023},
		'{1'b0, 6'd0,  16'sh8000, 1'b0, 16'sh0000},
		'{1'b0, 6'd0,  16'sh8000, 1'b0, 16'sh0000},
		'{1'b1, 6'd63, 16'sh8000, 1'b1, -16'sd1024},
		'{1'b0, 6'd0,  -16'sd1,   1'b0, 16'sh0000},
		'{1'b1, 6'd33, 16'sd7,    1'b1, 16'sh0000},
		'{1'b1, 6'd2,  -16'sd1,   1'b1, 16'sh0000},
		'{1'b0, 6'd0,  -16'sd2,   1'b0, 16'sh0000},
		'{1'b0, 6'd0,  -16'sd2,   1'b0, 16'sh0000},
		'{1'b1, 6'd1,  16'sd12345, 1'b1, 16'sd12345},
		'{1'b1, 6'd3,  16'sd1,    1'b0, 16'sh0000},
		'{1'b0, 6'd0,  16'sd2,    1'b0, 16'sh0000},
		'{1'b0, 6'd0,  16'sh7FFF, 1'b0, 16'sh0000},
		'{1'b0, 6'd0,  16'sh7FFF, 1'b0, 16'sh0000},
		'{1'b1, 6'd31, 16'sh8000, 1'b0, 16'sh0000},
		'{1'b0, 6'd0,  16'sh8000, 1'b0, 16'sh0000}
	};

	int phase_lens [7] = '{0, 32, 63, 1, 2, 33, 31};

	moving_average_filter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average(average)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_window();
		foreach (delay_line[i]) delay_line[i] = '0;
		window_total = 0;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] mean_of_window(
		input logic signed [SAMPLE_W-1:0] s
	);
		int span;
		if (win_len == 0)
			return s;
		span = (win_len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(win_len);
		window_total = window_total - delay_line[span-1] + s;
		for (int i = MAX_WINDOW_DEF - 1; i > 0; i--)
			delay_line[i] = delay_line[i-1];
		delay_line[0] = s;
		return SAMPLE_W'(window_total / span);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] next_sample();
		logic signed [SAMPLE_W-1:0] s;
		case ($urandom_range(0, 9))
			0: s = 16'sh7FFF;
			1: s = 16'sh8000;
			2: s = prev_sample;
			3: s = SAMPLE_W'($urandom_range(0, 128)) - 16'sd64;
			4: s = ($urandom_range(0, 1) != 0) ? 16'sh7FFF - SAMPLE_W'($urandom_range(0, 7))
				: 16'sh8000 + SAMPLE_W'($urandom_range(0, 7));
			default: s = SAMPLE_W'($urandom());
		endcase
		prev_sample = s;
		return s;
	endfunction

	// entered and left at a falling edge
	task automatic offer(input logic signed [SAMPLE_W-1:0] s, input logic typed,
		input logic signed [SAMPLE_W-1:0] want);
		logic signed [SAMPLE_W-1:0] guess;
		in_valid = 1'b1;
		sample = s;
		do @(posedge clk); while (!in_ready);
		guess = mean_of_window(s);
		pending_means.push_back(typed ? want : guess);
		@(negedge clk);
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (pending_means.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_len(input logic [LEN_W-1:0] v);
		settle();
		cfg_wen = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_wen = 1'b0;
		win_len = v;
		clear_window();
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_means.size() == 0) begin
				$error("average: no request pending, actual %0d", average);
				errors++;
			end else begin
				head_mean = pending_means.pop_front();
				if (average !== head_mean) begin
					$error("average: expected %0d, actual %0d", head_mean, average);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver stalls, with one long hold once traffic is flowing
	initial begin
		rx_mode_t    mode;
		int unsigned span;
		int unsigned tick;
		logic        held_long;
		out_ready = 1'b0;
		mode = RX_OPEN;
		span = 0;
		tick = 0;
		held_long = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_long && results_seen >= 300) begin
				out_ready = 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				held_long = 1'b1;
			end
			if (span == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				span = $urandom_range(20, 300);
			end
			span--;
			tick++;
			case (mode)
				RX_OPEN: out_ready = 1'b1;
				RX_COIN: out_ready = 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
				default: out_ready = (tick % 3 == 0);
			endcase
		end
	end

	initial begin
		int sent;
		int phase;
		int count;
		int burst_left;
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		sample = '0;
		errors = 0;
		results_seen = 0;
		cycle_count = 0;
		prev_sample = '0;
		win_len = WINDOW_RESET;
		clear_window();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (steps[i]) begin
			if (steps[i].set_len)
				write_len(steps[i].len);
			offer(steps[i].smp, steps[i].typed, steps[i].want);
		end

		sent = 0;
		phase = 0;
		burst_left = 0;
		while (sent < RANDOM_ITEMS) begin
			write_len(LEN_W'(phase < 7 ? phase_lens[phase] : $urandom_range(0, 63)));
			count = $urandom_range(80, 180);
			for (int k = 0; k < count; k++) begin
				if (phase == 2 && k == count / 2)
					settle();
				if (burst_left == 0) begin
					in_valid = 1'b0;
					repeat ($urandom_range(1, 15)) @(negedge clk);
					burst_left = $urandom_range(1, 60);
				end
				burst_left--;
				offer(next_sample(), 1'b0, '0);
				sent++;
			end
			phase++;
		end

		settle();
		if (pending_means.size() != 0) begin
			$error("average: %0d requests without result", pending_means.size());
			errors++;
		end
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/maf_pkg.sv
sv/maf_cell.sv
sv/maf_div.sv
sv/moving_average_filter.sv
sim/moving_average_filter_tb.sv
